FILE: design/rpu_pkg.sv
// ----------------------------------------------------------------------------
// rpu_pkg: shared types and constants of the raw pixel unpacker
// Pixel format codes, register indexes, size limits and the command word
// passed from the front (stream parser) to the back (pixel formatter).
// ----------------------------------------------------------------------------
package rpu_pkg;

  localparam int MAX_WIDTH  = 4096;
  localparam int MAX_HEIGHT = 4096;

  // image size registers and row/column counters
  localparam int SIZE_W = 13;
  localparam int IDX_W  = 24;
  localparam int KEY_W  = 24;
  localparam int CFG_IDX_W = 3;

  localparam logic [SIZE_W-1:0] MAX_W_SZ = SIZE_W'(MAX_WIDTH);
  localparam logic [SIZE_W-1:0] MAX_H_SZ = SIZE_W'(MAX_HEIGHT);

  typedef enum logic [1:0] {
    FMT_COPY24 = 2'd0,
    FMT_SWAP24 = 2'd1,
    FMT_RGB555 = 2'd2,
    FMT_RGB565 = 2'd3
  } fmt_t;

  localparam logic [CFG_IDX_W-1:0] REG_FORMAT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_ALPHA  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_KEY    = 3'd4;

  typedef struct packed {
    fmt_t              pixel_format;
    logic [SIZE_W-1:0] image_width;
    logic [SIZE_W-1:0] image_height;
    logic              alpha_plane_on;
    logic [KEY_W-1:0]  color_key;
  } cfg_t;

  // One finished pixel as classified by the front. For alpha-only writes the
  // alpha byte travels in d0; for 16-bit pixels d0 is the low byte, d1 high.
  typedef struct packed {
    logic             full;
    fmt_t             fmt;
    logic [7:0]       d0;
    logic [7:0]       d1;
    logic [7:0]       d2;
    logic [IDX_W-1:0] idx;
    logic             last;
  } cmd_t;

endpackage

FILE: design/rpu_front.sv
// ----------------------------------------------------------------------------
// rpu_front: byte stream parser
// Tracks byte phase, row/column position, padding and plane; issues one
// command word per completed pixel or alpha byte.
// ----------------------------------------------------------------------------
module rpu_front import rpu_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  logic       in_valid,
  input  logic [7:0] in_byte,
  input  logic       in_sof,
  output logic       in_ready,
  output logic       cmd_valid,
  output cmd_t       cmd,
  input  logic       cmd_ready
);

  logic [1:0]        byte_phase, byte_phase_next;
  logic [15:0]       held_bytes, held_bytes_next;
  logic [SIZE_W-1:0] column_count, column_count_next;
  logic [SIZE_W-1:0] row_count, row_count_next;
  logic [IDX_W-1:0]  running_index, running_index_next;
  logic              in_alpha_plane, in_alpha_plane_next;
  logic [1:0]        pad_left, pad_left_next;

  // state as seen after an optional start-of-image clear
  logic [1:0]        c_phase;
  logic [15:0]       c_held;
  logic [SIZE_W-1:0] c_col, c_row, col_inc, row_inc;
  logic [IDX_W-1:0]  c_idx;
  logic              c_in_a;
  logic [1:0]        c_pad;

  logic [SIZE_W-1:0] w, h;
  logic              at_end, do_adv, end_pl, emit;
  logic [1:0]        adv_pad;
  logic              accept;

  assign in_ready  = cmd_ready;
  assign accept    = in_valid && in_ready;
  assign cmd_valid = in_valid && emit;

  always_comb begin
    if (cfg.image_width == '0) w = SIZE_W'(1);
    else if (cfg.image_width > MAX_W_SZ) w = MAX_W_SZ;
    else w = cfg.image_width;
    if (cfg.image_height == '0) h = SIZE_W'(1);
    else if (cfg.image_height > MAX_H_SZ) h = MAX_H_SZ;
    else h = cfg.image_height;
  end

  always_comb begin
    c_phase = in_sof ? 2'd0 : byte_phase;
    c_held  = in_sof ? 16'd0 : held_bytes;
    c_col   = in_sof ? '0 : column_count;
    c_row   = in_sof ? '0 : row_count;
    c_idx   = in_sof ? '0 : running_index;
    c_in_a  = in_sof ? 1'b0 : in_alpha_plane;
    c_pad   = in_sof ? 2'd0 : pad_left;

    byte_phase_next     = c_phase;
    held_bytes_next     = c_held;
    column_count_next   = c_col;
    row_count_next      = c_row;
    running_index_next  = c_idx;
    in_alpha_plane_next = c_in_a;
    pad_left_next       = c_pad;

    col_inc = c_col + SIZE_W'(1);
    row_inc = c_row + SIZE_W'(1);
    at_end  = (col_inc >= w) && (row_inc >= h);
    do_adv  = 1'b0;
    end_pl  = 1'b0;
    adv_pad = 2'd0;
    emit    = 1'b0;

    cmd      = '0;
    cmd.fmt  = cfg.pixel_format;
    cmd.idx  = c_idx;

    if (c_pad != 2'd0) begin
      pad_left_next = c_pad - 2'd1;
      if (c_pad == 2'd1 && c_row >= h) end_pl = 1'b1;
    end else if (c_in_a) begin
      emit     = 1'b1;
      cmd.full = 1'b0;
      cmd.d0   = in_byte;
      cmd.last = at_end;
      do_adv   = 1'b1;
      adv_pad  = 2'd0 - w[1:0];       // alpha rows pad to 4 bytes
    end else if (!cfg.pixel_format[1]) begin
      case (c_phase)
        2'd0: begin
          held_bytes_next = {8'd0, in_byte};
          byte_phase_next = 2'd1;
        end
        2'd1: begin
          held_bytes_next = {in_byte, c_held[7:0]};
          byte_phase_next = 2'd2;
        end
        default: begin
          byte_phase_next = 2'd0;
          emit     = 1'b1;
          cmd.full = 1'b1;
          cmd.d0   = c_held[7:0];
          cmd.d1   = c_held[15:8];
          cmd.d2   = in_byte;
          cmd.last = at_end && !cfg.alpha_plane_on;
          do_adv   = 1'b1;
          adv_pad  = w[0] ? 2'd3 : 2'd0;  // odd-width rows carry 3 pad bytes
        end
      endcase
    end else begin
      if (c_phase == 2'd0) begin
        held_bytes_next = {8'd0, in_byte};
        byte_phase_next = 2'd1;
      end else begin
        byte_phase_next = 2'd0;
        emit     = 1'b1;
        cmd.full = 1'b1;
        cmd.d0   = c_held[7:0];
        cmd.d1   = in_byte;
        cmd.last = at_end && !cfg.alpha_plane_on;
        do_adv   = 1'b1;
      end
    end

    if (do_adv) begin
      running_index_next = c_idx + IDX_W'(1);
      if (col_inc >= w) begin
        column_count_next = '0;
        row_count_next    = row_inc;
        pad_left_next     = adv_pad;
        if (adv_pad == 2'd0 && row_inc >= h) end_pl = 1'b1;
      end else begin
        column_count_next = col_inc;
      end
    end

    if (end_pl) begin
      if (!c_in_a && cfg.alpha_plane_on) begin
        in_alpha_plane_next = 1'b1;
        held_bytes_next     = c_held;
      end else begin
        in_alpha_plane_next = 1'b0;
        held_bytes_next     = 16'd0;
      end
      byte_phase_next    = 2'd0;
      column_count_next  = '0;
      row_count_next     = '0;
      running_index_next = '0;
      pad_left_next      = 2'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_phase     <= 2'd0;
      held_bytes     <= 16'd0;
      column_count   <= '0;
      row_count      <= '0;
      running_index  <= '0;
      in_alpha_plane <= 1'b0;
      pad_left       <= 2'd0;
    end else if (accept) begin
      byte_phase     <= byte_phase_next;
      held_bytes     <= held_bytes_next;
      column_count   <= column_count_next;
      row_count      <= row_count_next;
      running_index  <= running_index_next;
      in_alpha_plane <= in_alpha_plane_next;
      pad_left       <= pad_left_next;
    end
  end

endmodule

FILE: design/rpu_queue.sv
// ----------------------------------------------------------------------------
// rpu_queue: two-entry command queue
// Decouples the parser from the formatter so each side stalls on its own.
// ----------------------------------------------------------------------------
module rpu_queue import rpu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push_valid,
  input  cmd_t push_data,
  output logic push_ready,
  output logic pop_valid,
  output cmd_t pop_data,
  input  logic pop_ready
);

  cmd_t       entry [2];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       push, pop;

  assign push_ready = (count != 2'd2);
  assign pop_valid  = (count != 2'd0);
  assign pop_data   = entry[rd_ptr];
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (push) entry[wr_ptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (pop)  rd_ptr <= ~rd_ptr;
      case ({push, pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

FILE: design/rpu_back.sv
// ----------------------------------------------------------------------------
// rpu_back: pixel formatter and output register
// Expands 16-bit pixels, orders 24-bit bytes, applies the color key and
// holds the finished word until the sink takes it.
// ----------------------------------------------------------------------------
module rpu_back import rpu_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  cfg_t             cfg,
  input  logic             cmd_valid,
  input  cmd_t             cmd,
  output logic             cmd_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [IDX_W-1:0] out_index,
  output logic             out_full,
  output logic [7:0]       out_b0,
  output logic [7:0]       out_b1,
  output logic [7:0]       out_b2,
  output logic [7:0]       out_alpha,
  output logic             out_last
);

  logic [7:0]  b0, b1, b2, a;
  logic [15:0] v;
  logic        load;

  assign cmd_ready = !out_valid || out_ready;
  assign load      = cmd_valid && cmd_ready;
  assign v         = {cmd.d1, cmd.d0};

  always_comb begin
    b0 = 8'd0;
    b1 = 8'd0;
    b2 = 8'd0;
    a  = 8'hff;
    if (!cmd.full) begin
      a = cmd.d0;
    end else begin
      case (cmd.fmt)
        FMT_COPY24: begin
          b0 = cmd.d0;
          b1 = cmd.d1;
          b2 = cmd.d2;
        end
        FMT_SWAP24: begin
          b0 = cmd.d2;
          b1 = cmd.d1;
          b2 = cmd.d0;
        end
        FMT_RGB555: begin
          b0 = {v[4:0], 3'd0};
          b1 = {v[9:5], 3'd0};
          b2 = {v[14:10], 3'd0};
        end
        FMT_RGB565: begin
          b0 = {v[4:0], 3'd0};
          b1 = {v[10:5], 2'd0};
          b2 = {v[15:11], 3'd0};
        end
        default: begin
          b0 = 8'd0;
        end
      endcase
      // key byte0 against out byte2, key byte2 against out byte0
      if (!cmd.fmt[1] && !cfg.alpha_plane_on &&
          cfg.color_key[7:0] == b2 && cfg.color_key[15:8] == b1 &&
          cfg.color_key[23:16] == b0)
        a = 8'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd_ready) begin
      out_valid <= cmd_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_index <= cmd.idx;
      out_full  <= cmd.full;
      out_b0    <= b0;
      out_b1    <= b1;
      out_b2    <= b2;
      out_alpha <= a;
      out_last  <= cmd.last;
    end
  end

endmodule

FILE: design/raw_pixel_to_rgba_unpacker.sv
// ----------------------------------------------------------------------------
// raw_pixel_to_rgba_unpacker: raw image byte stream to RGBA8888 pixel writes
// Parses 24-bit, RGB555 and RGB565 pixel data plus an optional alpha plane
// and emits indexed 32-bit pixel writes.
// ----------------------------------------------------------------------------
// One byte is taken per clock on the slave stream, sustained. Each byte that
// completes a pixel (or each alpha-plane byte) yields one output word, held
// first in the command queue and then in the output register. Padding bytes
// and the leading bytes of a pixel yield nothing. The parser stalls only when
// the two-entry queue is full, which happens only after the sink has held
// m_tready low. Sizes of 0 act as 1, and sizes above 4096 act as 4096.
// Program the registers only while the block is idle; start_of_image
// (s_tuser) restarts all counters on its byte.
// ----------------------------------------------------------------------------
module raw_pixel_to_rgba_unpacker import rpu_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  // input byte stream
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [7:0] data_byte
  input  logic                 s_tuser,   // [0] start_of_image
  // output pixel writes
  output logic                 m_tvalid,
  input  logic                 m_tready,
  output logic [55:0]          m_tdata,   // [23:0] pixel_index, [31:24] out_byte0,
                                          // [39:32] out_byte1, [47:40] out_byte2,
                                          // [55:48] alpha_out
  output logic                 m_tuser,   // [0] full_write
  output logic                 m_tlast,   // last_write
  // register writes
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [KEY_W-1:0]     cfg_data
);

  cfg_t       cfg;
  logic       f_valid, f_ready, q_valid, q_ready;
  cmd_t       f_cmd, q_cmd;
  logic [7:0] o_b0, o_b1, o_b2, o_alpha;
  logic [IDX_W-1:0] o_index;

  // Register file: always ready, out-of-range indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pixel_format   <= FMT_COPY24;
      cfg.image_width    <= SIZE_W'(1);
      cfg.image_height   <= SIZE_W'(1);
      cfg.alpha_plane_on <= 1'b0;
      cfg.color_key      <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_FORMAT: cfg.pixel_format   <= fmt_t'(cfg_data[1:0]);
        REG_WIDTH:  cfg.image_width    <= cfg_data[SIZE_W-1:0];
        REG_HEIGHT: cfg.image_height   <= cfg_data[SIZE_W-1:0];
        REG_ALPHA:  cfg.alpha_plane_on <= cfg_data[0];
        REG_KEY:    cfg.color_key      <= cfg_data;
        default:    cfg.color_key      <= cfg.color_key;
      endcase
    end
  end

  // Front: parses bytes, tracks position, classifies completed pixels.
  rpu_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (s_tvalid),
    .in_byte   (s_tdata),
    .in_sof    (s_tuser),
    .in_ready  (s_tready),
    .cmd_valid (f_valid),
    .cmd       (f_cmd),
    .cmd_ready (f_ready)
  );

  // Queue between parser and formatter.
  rpu_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (f_valid),
    .push_data  (f_cmd),
    .push_ready (f_ready),
    .pop_valid  (q_valid),
    .pop_data   (q_cmd),
    .pop_ready  (q_ready)
  );

  // Back: builds the RGBA word and holds it for the sink.
  rpu_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .cmd_valid (q_valid),
    .cmd       (q_cmd),
    .cmd_ready (q_ready),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_index (o_index),
    .out_full  (m_tuser),
    .out_b0    (o_b0),
    .out_b1    (o_b1),
    .out_b2    (o_b2),
    .out_alpha (o_alpha),
    .out_last  (m_tlast)
  );

  assign m_tdata = {o_alpha, o_b2, o_b1, o_b0, o_index};

endmodule
